### hdl/min_cover_window_finder_unit_assert.svh
// ----------------------------------------------------------------------------
// min_cover_window_finder_unit_assert.svh
// Assertion macros used by the window finder top level.
// ----------------------------------------------------------------------------
`ifndef MIN_COVER_WINDOW_FINDER_UNIT_ASSERT_SVH
`define MIN_COVER_WINDOW_FINDER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MCW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MCW_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MCW_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg
// Sizes, codes and controller/datapath interface types of the window finder.
// ----------------------------------------------------------------------------
package mcw_pkg;

   localparam int MAX_TEXT    = 4096;
   localparam int MAX_PATTERN = 4096;
   localparam int ALPHABET    = 128;

   localparam int CH_W    = 7;
   localparam int START_W = 12;
   localparam int LEN_W   = 13;

   localparam int WIN_AW = $clog2(MAX_TEXT);       // window buffer address
   localparam int POS_W  = $clog2(MAX_TEXT) + 1;   // text position, holds MAX_TEXT
   localparam int CNT_W  = $clog2(MAX_PATTERN) + 1; // missing count
   localparam int DEM_W  = CNT_W + 1;              // signed demand
   localparam int DEM_AW = $clog2(ALPHABET);       // demand table address

   // demand read address source
   localparam logic SEL_CH  = 1'b0;
   localparam logic SEL_WIN = 1'b1;

   // input kinds
   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   typedef struct packed {
      logic dem_rd;      // read demand entry
      logic dem_sel;     // SEL_CH or SEL_WIN
      logic pat_add;     // demand +1, missing +1
      logic txt_sub;     // demand -1, missing -1 if demand was positive
      logic drop_add;    // demand +1, missing +1 if demand was zero
      logic win_wr;      // store char at next position
      logic win_rd;      // record window, read front char, advance front
      logic empty_text;  // text beat with nothing missing
      logic set_text;    // text phase begins
      logic set_ovf;     // truncation seen
      logic finish;      // load result, clear job
   } mcw_cmd_type;

   typedef struct packed {
      logic text_phase;
      logic miss_zero;
      logic pat_full;
      logic text_full;
      logic window_open;
      logic rsp_free;
   } mcw_stat_type;

endpackage

### hdl/min_cover_window_finder_unit.sv
// ----------------------------------------------------------------------------
// min_cover_window_finder_unit
// Shortest text window covering a pattern (with multiplicity).
//
// Usage: a job sends pattern beats (req_tuser = 0), then text beats
// (req_tuser = 1), char code in req_tdata[6:0]. The text beat with req_tlast
// set closes the job and yields one rsp beat: found, start, length, overflow.
// Pattern beats after text, and tlast on a pattern beat, are ignored.
// Text beyond 4096 chars or pattern beyond 4096 chars sets overflow.
// Each pattern beat is a demand read-modify-write on the single-port demand
// table. Each text beat stores its char and updates its demand, then drops
// chars from the window front while the window covers the pattern, each
// drop being a window read then a demand read-modify-write; each char is
// dropped at most once. Ignored, truncated and empty-pattern beats need no
// demand update. req_tready is low until a beat's updates are done, and
// rsp_tvalid rises once the closing beat's updates are done; a stalled rsp
// side holds the result in the output register and only the next closing
// beat waits on it, with req_tready low. Reset (and the end of every job)
// clears counters and demand valid bits; the window buffer is never cleared.
// ----------------------------------------------------------------------------
`include "min_cover_window_finder_unit_assert.svh"

module min_cover_window_finder_unit
   import mcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] ch, [7] zero pad
   input  logic        req_tuser,   // [0] op: 0 pattern, 1 text
   input  logic        req_tlast,   // last text char of the job
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] min_start, [24:12] min_len, [31:25] zero
   output logic [1:0]  rsp_tuser    // [0] found, [1] overflow
);

   mcw_cmd_type  cmd;
   mcw_stat_type stat;

   logic               rsp_found;
   logic [START_W-1:0] rsp_start;
   logic [LEN_W-1:0]   rsp_len;
   logic               rsp_ovf;

   // sequencer
   mcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_last   (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // tables, counters and result register
   mcw_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .ch_in      (req_tdata[CH_W-1:0]),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_found  (rsp_found),
      .rsp_start  (rsp_start),
      .rsp_len    (rsp_len),
      .rsp_ovf    (rsp_ovf)
   );

   assign rsp_tdata = {7'd0, rsp_len, rsp_start};
   assign rsp_tuser = {rsp_ovf, rsp_found};

   // ---- assertions ----
   `MCW_ASSERT_NXT(a_finish_gives_beat, clock, reset, cmd.finish, rsp_tvalid,
      "finish did not present a result beat")
   `MCW_ASSERT_IMP(a_shrink_only_covered, clock, reset, cmd.win_rd,
      stat.miss_zero && stat.window_open, "window shrink while not covering")
   `MCW_ASSERT_NXT(a_store_then_sub, clock, reset, cmd.win_wr, cmd.txt_sub,
      "stored text char not followed by demand update")

endmodule

### hdl/mcw_ctrl.sv
// ----------------------------------------------------------------------------
// mcw_ctrl
// Sequencer: takes beats, steps the demand/window updates and the shrink loop.
// ----------------------------------------------------------------------------
module mcw_ctrl
   import mcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_op,
   input  logic         req_last,
   output logic         req_tready,
   input  mcw_stat_type stat,
   output mcw_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PAT      = 3'd1;
   localparam logic [2:0] S_TXT      = 3'd2;
   localparam logic [2:0] S_CHECK    = 3'd3;
   localparam logic [2:0] S_DROP_RD  = 3'd4;
   localparam logic [2:0] S_DROP_UPD = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_PATTERN) begin
                  if (stat.text_phase) begin
                     // late pattern char: dropped
                  end else if (stat.pat_full) begin
                     cmd.set_ovf = 1'b1;
                  end else begin
                     cmd.dem_rd  = 1'b1;
                     cmd.dem_sel = SEL_CH;
                     state_in    = S_PAT;
                  end
               end else begin
                  cmd.set_text = 1'b1;
                  last_in      = req_last;
                  if (stat.miss_zero) begin
                     cmd.empty_text = 1'b1;
                     if (req_last) state_in = S_FINISH;
                  end else if (stat.text_full) begin
                     cmd.set_ovf = 1'b1;
                     if (req_last) state_in = S_FINISH;
                  end else begin
                     cmd.win_wr  = 1'b1;
                     cmd.dem_rd  = 1'b1;
                     cmd.dem_sel = SEL_CH;
                     state_in    = S_TXT;
                  end
               end
            end
         end
         S_PAT: begin
            cmd.pat_add = 1'b1;
            state_in    = S_IDLE;
         end
         S_TXT: begin
            cmd.txt_sub = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (stat.miss_zero && stat.window_open) begin
               cmd.win_rd = 1'b1;
               state_in   = S_DROP_RD;
            end else begin
               state_in = last_ff ? S_FINISH : S_IDLE;
            end
         end
         S_DROP_RD: begin
            cmd.dem_rd  = 1'b1;
            cmd.dem_sel = SEL_WIN;
            state_in    = S_DROP_UPD;
         end
         S_DROP_UPD: begin
            cmd.drop_add = 1'b1;
            state_in     = S_CHECK;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

### hdl/mcw_datapath.sv
// ----------------------------------------------------------------------------
// mcw_datapath
// Demand table, window buffer, counters, best window and result register.
// ----------------------------------------------------------------------------
module mcw_datapath
   import mcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  mcw_cmd_type         cmd,
   input  logic [CH_W-1:0]     ch_in,
   output mcw_stat_type        stat,
   input  logic                rsp_tready,
   output logic                rsp_valid,
   output logic                rsp_found,
   output logic [START_W-1:0]  rsp_start,
   output logic [LEN_W-1:0]    rsp_len,
   output logic                rsp_ovf
);

   // demand table: memory plus per-entry valid bits (invalid reads as zero)
   logic signed [DEM_W-1:0] dem_mem [ALPHABET];
   logic [ALPHABET-1:0]     dem_vld_ff;
   logic signed [DEM_W-1:0] dem_q;
   logic                    dv_q;
   logic [DEM_AW-1:0]       dem_addr;
   logic [DEM_AW-1:0]       addr_ff;
   logic signed [DEM_W-1:0] dem_val;
   logic signed [DEM_W-1:0] dem_wdata;
   logic                    dem_we;

   // window buffer
   logic [CH_W-1:0]   win_mem [MAX_TEXT];
   logic [CH_W-1:0]   win_q;

   logic [CNT_W-1:0]  missing_ff;
   logic [POS_W-1:0]  front_ff;
   logic [POS_W-1:0]  next_ff;
   logic [WIN_AW-1:0] best_start_ff;
   logic [POS_W-1:0]  best_len_ff;
   logic              best_valid_ff;
   logic              text_phase_ff;
   logic              ovf_ff;
   logic [POS_W-1:0]  cur_len;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [START_W-1:0] rsp_start_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic              rsp_ovf_ff;

   assign dem_addr  = (cmd.dem_sel == SEL_WIN) ? win_q[DEM_AW-1:0] : ch_in[DEM_AW-1:0];
   assign dem_val   = dv_q ? dem_q : '0;
   assign dem_we    = cmd.pat_add || cmd.txt_sub || cmd.drop_add;
   assign dem_wdata = cmd.txt_sub ? dem_val - DEM_W'(1) : dem_val + DEM_W'(1);
   assign cur_len   = next_ff - front_ff;

   assign stat.text_phase  = text_phase_ff;
   assign stat.miss_zero   = (missing_ff == '0);
   assign stat.pat_full    = (missing_ff >= CNT_W'(MAX_PATTERN));
   assign stat.text_full   = (next_ff >= POS_W'(MAX_TEXT));
   assign stat.window_open = (front_ff < next_ff);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_tready;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.dem_rd) begin
         dem_q <= dem_mem[dem_addr];
         dv_q  <= dem_vld_ff[dem_addr];
      end
      if (dem_we) begin
         dem_mem[addr_ff] <= dem_wdata;
      end
      if (cmd.dem_rd) begin
         addr_ff <= dem_addr;
      end
      if (cmd.win_wr) begin
         win_mem[next_ff[WIN_AW-1:0]] <= ch_in;
      end
      if (cmd.win_rd) begin
         win_q <= win_mem[front_ff[WIN_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dem_vld_ff    <= '0;
         missing_ff    <= '0;
         front_ff      <= '0;
         next_ff       <= '0;
         best_start_ff <= '0;
         best_len_ff   <= '0;
         best_valid_ff <= 1'b0;
         text_phase_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else if (cmd.finish) begin
         dem_vld_ff    <= '0;
         missing_ff    <= '0;
         front_ff      <= '0;
         next_ff       <= '0;
         best_start_ff <= '0;
         best_len_ff   <= '0;
         best_valid_ff <= 1'b0;
         text_phase_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         if (dem_we) dem_vld_ff[addr_ff] <= 1'b1;
         if (cmd.set_text) text_phase_ff <= 1'b1;
         if (cmd.set_ovf) ovf_ff <= 1'b1;

         if (cmd.pat_add) begin
            missing_ff <= missing_ff + CNT_W'(1);
         end else if (cmd.txt_sub) begin
            if (!dem_val[DEM_W-1] && (dem_val != '0)) missing_ff <= missing_ff - CNT_W'(1);
         end else if (cmd.drop_add) begin
            if (dem_val == '0) missing_ff <= missing_ff + CNT_W'(1);
         end

         if (cmd.win_wr) next_ff <= next_ff + POS_W'(1);

         if (cmd.empty_text) begin
            best_valid_ff <= 1'b1;
            best_start_ff <= '0;
            best_len_ff   <= '0;
            if (stat.text_full) ovf_ff <= 1'b1;
            else next_ff <= next_ff + POS_W'(1);
         end

         if (cmd.win_rd) begin
            // strictly shorter only: earliest shortest window wins
            if (!best_valid_ff || (cur_len < best_len_ff)) begin
               best_valid_ff <= 1'b1;
               best_start_ff <= front_ff[WIN_AW-1:0];
               best_len_ff   <= cur_len;
            end
            front_ff <= front_ff + POS_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_found_ff <= best_valid_ff;
         rsp_start_ff <= best_valid_ff ? START_W'(best_start_ff) : '0;
         rsp_len_ff   <= best_valid_ff ? LEN_W'(best_len_ff) : '0;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_start = rsp_start_ff;
   assign rsp_len   = rsp_len_ff;
   assign rsp_ovf   = rsp_ovf_ff;

endmodule

### tb/sv/window_cover_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_cover_checker
// Watches the req and rsp channels of the window finder. Each accepted req
// beat is run through a cycle-free copy of the job state; a closing text beat
// queues the expected result, and each accepted rsp beat is compared against
// the oldest one, field by field.
// ----------------------------------------------------------------------------
module window_cover_checker
   import mcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] ch, [7] zero pad
   input  logic        req_tuser,   // [0] op
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [11:0] min_start, [24:12] min_len, [31:25] zero
   input  logic [1:0]  rsp_tuser,   // [0] found, [1] overflow
   output int          fail_count,
   output int          results_due
);

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
      logic               overflow;
   } cover_result_type;

   // job state
   logic signed [DEM_W-1:0] demand [ALPHABET];
   logic [CNT_W-1:0]        missing;
   logic [CH_W-1:0]         window_buf [MAX_TEXT];
   logic [POS_W-1:0]        front_pos;
   logic [POS_W-1:0]        fill_pos;
   logic [START_W-1:0]      best_start;
   logic [LEN_W-1:0]        best_len;
   logic                    best_valid;
   logic                    in_text;
   logic                    truncated;

   cover_result_type cover_due_q[$];
   int               errors_seen = 0;

   assign fail_count = errors_seen;

   task automatic report_mismatch(input string msg);
      $display("checker: %0t ns: %s", $time, msg);
      errors_seen++;
   endtask

   task automatic clear_cover_job();
      foreach (demand[i]) demand[i] = '0;
      missing    = '0;
      front_pos  = '0;
      fill_pos   = '0;
      best_start = '0;
      best_len   = '0;
      best_valid = 1'b0;
      in_text    = 1'b0;
      truncated  = 1'b0;
   endtask

   // store one text char, then shrink the window from the front while it
   // still covers the pattern, keeping the first strictly shorter window
   task automatic absorb_text_char(input logic [CH_W-1:0] c);
      logic [CH_W-1:0]  d;
      logic [POS_W-1:0] span;
      if (fill_pos >= MAX_TEXT) begin
         truncated = 1'b1;
         return;
      end
      window_buf[fill_pos[WIN_AW-1:0]] = c;
      fill_pos++;
      if (demand[c] > 0) missing--;
      demand[c]--;
      while (missing == 0 && front_pos < fill_pos) begin
         span = fill_pos - front_pos;
         if (!best_valid || span < best_len) begin
            best_valid = 1'b1;
            best_start = front_pos[START_W-1:0];
            best_len   = span;
         end
         d = window_buf[front_pos[WIN_AW-1:0]];
         front_pos++;
         if (demand[d] == 0) missing++;
         demand[d]++;
      end
   endtask

   task automatic track_window_beat(input logic op, input logic [CH_W-1:0] c,
                                    input logic last);
      cover_result_type r;
      if (op == OP_PATTERN) begin
         // pattern after text is dropped; a full pattern only flags truncation
         if (in_text) return;
         if (missing >= MAX_PATTERN) begin
            truncated = 1'b1;
            return;
         end
         demand[c]++;
         missing++;
         return;
      end
      in_text = 1'b1;
      if (missing == 0) begin
         // empty pattern: zero-length window at the start
         best_valid = 1'b1;
         best_start = '0;
         best_len   = '0;
         if (fill_pos >= MAX_TEXT) truncated = 1'b1;
         else fill_pos++;
      end else begin
         absorb_text_char(c);
      end
      if (last) begin
         r.found    = best_valid;
         r.start    = best_valid ? best_start : '0;
         r.len      = best_valid ? best_len : '0;
         r.overflow = truncated;
         cover_due_q.push_back(r);
         clear_cover_job();
      end
   endtask

   task automatic check_result(input logic found, input logic [START_W-1:0] start,
                               input logic [LEN_W-1:0] len, input logic overflow);
      cover_result_type want;
      if (cover_due_q.size() == 0) begin
         report_mismatch($sformatf("rsp beat with none due: found %0d start %0d len %0d ovf %0d",
                                   found, start, len, overflow));
         return;
      end
      want = cover_due_q.pop_front();
      if (found !== want.found)
         report_mismatch($sformatf("found %0d, want %0d", found, want.found));
      if (start !== want.start)
         report_mismatch($sformatf("min_start %0d, want %0d", start, want.start));
      if (len !== want.len)
         report_mismatch($sformatf("min_len %0d, want %0d", len, want.len));
      if (overflow !== want.overflow)
         report_mismatch($sformatf("overflow %0d, want %0d", overflow, want.overflow));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_cover_job();
         cover_due_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result(rsp_tuser[0], rsp_tdata[11:0], rsp_tdata[24:12], rsp_tuser[1]);
         if (req_tvalid && req_tready)
            track_window_beat(req_tuser, req_tdata[CH_W-1:0], req_tlast);
      end
      results_due <= cover_due_q.size();
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pattern/text jobs into the window finder and gives the verdict.
// A short directed set covers the corner cases, then random jobs over small
// alphabets. Results are predicted and checked by window_cover_checker.
// ----------------------------------------------------------------------------
module testbench;
   import mcw_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [6:0] ch, [7] zero pad
   logic        req_tuser  = 1'b0;  // [0] op: 0 pattern, 1 text
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [11:0] min_start, [24:12] min_len, [31:25] zero
   logic [1:0]  rsp_tuser;          // [0] found, [1] overflow
   int          fail_count;
   int          results_due;

   // one req beat as queued by the job builders
   typedef struct packed {
      logic            op;
      logic [CH_W-1:0] ch;
      logic            last;
   } req_beat_type;

   // receiver stall patterns
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   req_beat_type job_q[$];
   int           burst_left    = 0;
   int           counted_beats = 0;   // random beats that the block acts on

   always #5 clock = ~clock;

   min_cover_window_finder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   window_cover_checker cover_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   task automatic queue_beat(input logic op, input logic [CH_W-1:0] ch, input logic last);
      req_beat_type b;
      b.op   = op;
      b.ch   = ch;
      b.last = last;
      job_q.push_back(b);
   endtask

   // Present one beat and hold it until accepted. The sender runs in bursts:
   // valid stays high across a burst, then drops for a short random gap.
   task automatic send_beat(input req_beat_type b);
      int gap;
      req_tuser  <= b.op;
      req_tdata  <= {1'b0, b.ch};
      req_tlast  <= b.last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         // now and then a long run with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic flush_job();
      foreach (job_q[i]) send_beat(job_q[i]);
      job_q.delete();
   endtask

   // Random job over a tiny alphabet so that windows close often. Noise:
   // tlast on pattern beats, stray pattern beats once text has begun, and
   // foreign chars in the text.
   task automatic build_random_job();
      logic [CH_W-1:0] syms [4];
      int              nsym;
      int              plen;
      int              tlen;
      logic [CH_W-1:0] c;
      nsym = $urandom_range(1, 4);
      foreach (syms[i]) syms[i] = CH_W'($urandom_range(0, 127));
      plen = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < plen; i++)
         queue_beat(OP_PATTERN, syms[$urandom_range(0, nsym - 1)],
                    $urandom_range(0, 9) == 0);
      tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 40);
      for (int i = 0; i < tlen; i++) begin
         c = ($urandom_range(0, 6) == 0) ? CH_W'($urandom_range(0, 127))
                                         : syms[$urandom_range(0, nsym - 1)];
         queue_beat(OP_TEXT, c, i == tlen - 1);
         // ignored by the block, not counted
         if (i < tlen - 1 && $urandom_range(0, 19) == 0)
            queue_beat(OP_PATTERN, CH_W'($urandom_range(0, 127)),
                       1'($urandom_range(0, 1)));
      end
      counted_beats += plen + tlen;
   endtask

   // Receiver: switches at random between stall patterns. Once,
   // early in the random phase, it holds off long enough that a finished
   // result sits in the output register and the next closing beat backs up
   // the req side.
   initial begin
      rx_mode_type mode;
      int          span;
      int          ticks;
      bit          held;
      ticks = 0;
      held  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && ticks >= 3000) begin
            held = 1'b1;
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (4000) @(posedge clock);
            ticks += 4001;
         end
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 160);
         repeat (span) begin
            @(posedge clock);
            ticks++;
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
               default:   rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // empty pattern, single closing text beat
      queue_beat(OP_TEXT, 7'h41, 1'b1);
      // empty pattern over two beats, char code extremes
      queue_beat(OP_TEXT, 7'h7f, 1'b0);
      queue_beat(OP_TEXT, 7'h00, 1'b1);
      // tlast on a pattern beat is ignored
      queue_beat(OP_PATTERN, 7'h61, 1'b0);
      queue_beat(OP_PATTERN, 7'h62, 1'b1);
      queue_beat(OP_TEXT, 7'h63, 1'b0);
      queue_beat(OP_TEXT, 7'h61, 1'b0);
      queue_beat(OP_TEXT, 7'h62, 1'b1);
      // pattern longer than text: nothing found
      queue_beat(OP_PATTERN, 7'h78, 1'b0);
      queue_beat(OP_PATTERN, 7'h79, 1'b0);
      queue_beat(OP_PATTERN, 7'h7a, 1'b0);
      queue_beat(OP_TEXT, 7'h78, 1'b0);
      queue_beat(OP_TEXT, 7'h79, 1'b1);
      // repeated pattern char; a pattern beat once text has begun is dropped
      queue_beat(OP_PATTERN, 7'h61, 1'b0);
      queue_beat(OP_PATTERN, 7'h61, 1'b0);
      queue_beat(OP_TEXT, 7'h61, 1'b0);
      queue_beat(OP_TEXT, 7'h62, 1'b0);
      queue_beat(OP_PATTERN, 7'h62, 1'b1);
      queue_beat(OP_TEXT, 7'h61, 1'b1);
      // code extremes in the pattern
      queue_beat(OP_PATTERN, 7'h00, 1'b0);
      queue_beat(OP_PATTERN, 7'h7f, 1'b0);
      queue_beat(OP_TEXT, 7'h7f, 1'b0);
      queue_beat(OP_TEXT, 7'h05, 1'b0);
      queue_beat(OP_TEXT, 7'h00, 1'b1);
      flush_job();

      // --- random ---
      while (counted_beats < 1550) begin
         build_random_job();
         flush_job();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      // let a late or stray rsp beat show up
      repeat (50) @(posedge clock);

      if (fail_count == 0 && results_due == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
